### hdl/pidaw_pkg.sv
`default_nettype none
package pidaw_pkg;

  localparam int unsigned DW         = 32;
  localparam int unsigned IDX_W      = 31;
  localparam int unsigned AREA_W     = 31;
  localparam int unsigned DT_W       = 31;
  localparam int unsigned LIM_W      = 31;
  localparam int unsigned PER_W      = 16;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned WIDE_W     = 62;
  localparam int unsigned SUM_W      = 63;
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PROD_W     = 80;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [LIM_W-1:0] STEP_LIMIT_RST = 31'd6554;
  localparam logic [DW-1:0]    DRIVE_MIN      = 32'h8000_0000;
  localparam logic [DW-1:0]    DRIVE_MAX      = 32'h7fff_ffff;
  localparam logic [PER_W-1:0] PERIOD_RST     = 16'd1;

  localparam logic [PROD_W-1:0] WIDE_LIM_NEG =
    {{(PROD_W-WIDE_W){1'b0}}, 1'b1, {(WIDE_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] WIDE_LIM_POS = WIDE_LIM_NEG - {{(PROD_W-1){1'b0}}, 1'b1};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ERROR_MODE     = 3'd0,
    REG_DENSITY_TARGET = 3'd1,
    REG_GAIN_PROP      = 3'd2,
    REG_GAIN_INTEG     = 3'd3,
    REG_STEP_LIMIT     = 3'd4,
    REG_DRIVE_FLOOR    = 3'd5,
    REG_DRIVE_CEILING  = 3'd6,
    REG_UPDATE_PERIOD  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic go;
    logic clr;
    logic hi;
    logic neg;
  } mac_ctl_t;

  function automatic logic [DW-1:0] abs32(input logic signed [DW-1:0] x);
    abs32 = x[DW-1] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [DW-2:0] mag31(input logic signed [DW-1:0] x);
    logic [DW-1:0] a;
    a = abs32(x);
    mag31 = (x == DRIVE_MIN) ? {(DW-1){1'b1}} : a[DW-2:0];
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [SUM_W-1:0] x);
    if (x[SUM_W-1:DW-1] != {(SUM_W-DW+1){x[SUM_W-1]}}) begin
      sat32 = x[SUM_W-1] ? DRIVE_MIN : DRIVE_MAX;
    end else begin
      sat32 = x[DW-1:0];
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [SUM_W-1:0] x);
    if (x[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){x[SUM_W-1]}}) begin
      sat48 = x[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat48 = x[ACC_W-1:0];
    end
  endfunction

  function automatic logic signed [DW-1:0] clamp_drv(input logic signed [DW:0] x,
                                                     input logic signed [DW-1:0] lo,
                                                     input logic signed [DW-1:0] hi);
    logic signed [DW:0] y;
    y = x;
    if (y > $signed({hi[DW-1], hi})) y = $signed({hi[DW-1], hi});
    if (y < $signed({lo[DW-1], lo})) y = $signed({lo[DW-1], lo});
    clamp_drv = y[DW-1:0];
  endfunction

endpackage
`default_nettype wire

### hdl/pidaw_if.sv
`default_nettype none
interface pidaw_in_if import pidaw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         step_index;
  logic signed [DW-1:0]     plane_flux;
  logic [AREA_W-1:0]        plane_area;
  logic [DT_W-1:0]          step_length;
  logic signed [DW-1:0]     start_value;

  modport source(output valid, step_index, plane_flux, plane_area, step_length, start_value,
                 input ready);
  modport sink(input valid, step_index, plane_flux, plane_area, step_length, start_value,
               output ready);
endinterface

interface pidaw_out_if import pidaw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] drive_value;
  logic signed [DW-1:0] error_value;
  logic                 did_update;

  modport source(output valid, drive_value, error_value, did_update, input ready);
  modport sink(input valid, drive_value, error_value, did_update, output ready);
endinterface
`default_nettype wire

### hdl/pi_drive_controller_antiwindup_core.sv
// A request on which the controller does not run goes from the idle state to the finish state, then to the result.
// A run in total mode makes five passes through the shared multiplier.
// A run in average mode first runs the bit-serial divider, then makes four
// multiplier passes. One request at a time.
// Reset (synchronous, rst_n low) clears the drive, integrator and step index and
// loads the register defaults; the next request is again taken as the first.
`default_nettype none
module pi_drive_controller_antiwindup_core import pidaw_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pidaw_in_if.sink              in_ch,
  pidaw_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned DIVW = IDX_W + FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_ISSUE, ST_MUL, ST_DU, ST_DRV, ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_GOAL, OP_INT, OP_PRO, OP_IGL, OP_IGH
  } op_t;

  state_t state_r;
  op_t    op_r;

  logic                     mode_r;
  logic signed [DW-1:0]     target_r, gp_r, gi_r, floor_r, ceil_r;
  logic [LIM_W-1:0]         lim_r;
  logic [PER_W-1:0]         period_r;

  logic signed [DW-1:0]     drive_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [IDX_W-1:0]         last_r;
  logic                     started_r;

  logic [DW-2:0]            mag_r;
  logic [AREA_W-1:0]        area_r;
  logic [DT_W-1:0]          dt_r;
  logic signed [DW-1:0]     err_r;
  logic                     did_r;
  logic signed [WIDE_W-1:0] p_r, i_r;
  logic signed [DW-1:0]     du_r;

  logic                     out_valid_r;
  logic signed [DW-1:0]     out_drive_r, out_err_r;
  logic                     out_did_r;

  logic                     accept;
  logic [DW-2:0]            mag_c;
  logic signed [DW-1:0]     step_diff;
  logic [PER_W-1:0]         period_eff;
  logic                     due;
  logic                     run;

  mac_ctl_t                 mac_ctl;
  logic [MUL_W-1:0]         mac_a, mac_b;
  logic                     mac_done;
  logic signed [WIDE_W-1:0] mac_res;
  logic [ACC_W-1:0]         acc_mag;
  logic [DW-1:0]            err_mag, gi_mag;

  logic                     div_start, div_done;
  logic [DIVW-1:0]          div_q;
  logic [DW-2:0]            javg;

  logic signed [SUM_W-1:0]  goal_diff, int_sum, du_sum, du_lim, lim_pos;
  logic signed [DW:0]       avg_diff, drive_diff;
  logic                     windup;

  assign accept     = in_ch.valid && in_ch.ready;
  assign mag_c      = mag31(in_ch.plane_flux);
  assign step_diff  = $signed({1'b0, in_ch.step_index}) - $signed({1'b0, last_r});
  assign period_eff = (period_r == '0) ? PERIOD_RST : period_r;
  assign due        = step_diff >= $signed({{(DW-PER_W){1'b0}}, period_eff});
  assign run        = due && (in_ch.plane_area != '0);
  assign div_start  = accept && started_r && run && mode_r;

  assign acc_mag = acc_r[ACC_W-1] ? (~acc_r + 1'b1) : acc_r;
  assign err_mag = abs32(err_r);
  assign gi_mag  = abs32(gi_r);

  always_comb begin
    mac_ctl.go  = (state_r == ST_ISSUE);
    mac_ctl.clr = 1'b1;
    mac_ctl.hi  = 1'b0;
    unique case (op_r)
      OP_GOAL: begin
        mac_a       = abs32(target_r);
        mac_b       = {1'b0, area_r};
        mac_ctl.neg = target_r[DW-1];
      end
      OP_INT: begin
        mac_a       = err_mag;
        mac_b       = {1'b0, dt_r};
        mac_ctl.neg = err_r[DW-1];
      end
      OP_PRO: begin
        mac_a       = abs32(gp_r);
        mac_b       = err_mag;
        mac_ctl.neg = gp_r[DW-1] ^ err_r[DW-1];
      end
      OP_IGL: begin
        mac_a       = gi_mag;
        mac_b       = acc_mag[MUL_W-1:0];
        mac_ctl.neg = gi_r[DW-1] ^ acc_r[ACC_W-1];
      end
      OP_IGH: begin
        mac_a       = gi_mag;
        mac_b       = {{(2*MUL_W-ACC_W){1'b0}}, acc_mag[ACC_W-1:MUL_W]};
        mac_ctl.neg = gi_r[DW-1] ^ acc_r[ACC_W-1];
        mac_ctl.clr = 1'b0;
        mac_ctl.hi  = 1'b1;
      end
      default: begin
        mac_a       = '0;
        mac_b       = '0;
        mac_ctl.neg = 1'b0;
      end
    endcase
  end

  pidaw_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .done  (mac_done),
    .res   (mac_res)
  );

  pidaw_div #(.NUM_W(DIVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({mag_c, {FRAC_BITS{1'b0}}}),
    .divisor  (in_ch.plane_area),
    .done     (div_done),
    .quotient (div_q)
  );

  assign javg      = (div_q[DIVW-1:DW-1] != '0) ? {(DW-1){1'b1}} : div_q[DW-2:0];
  assign avg_diff  = $signed({target_r[DW-1], target_r}) - $signed({2'b00, javg});
  assign goal_diff = $signed({mac_res[WIDE_W-1], mac_res}) - $signed({{(SUM_W-DW+1){1'b0}}, mag_r});
  assign int_sum   = $signed({{(SUM_W-ACC_W){acc_r[ACC_W-1]}}, acc_r})
                   + $signed({mac_res[WIDE_W-1], mac_res});
  assign du_sum    = $signed({p_r[WIDE_W-1], p_r}) + $signed({i_r[WIDE_W-1], i_r});
  assign lim_pos   = $signed({{(SUM_W-LIM_W){1'b0}}, lim_r});

  always_comb begin
    du_lim = du_sum;
    if (du_lim > lim_pos) du_lim = lim_pos;
    if (du_lim < -lim_pos) du_lim = -lim_pos;
  end

  assign drive_diff = $signed({drive_r[DW-1], drive_r}) - $signed({du_r[DW-1], du_r});
  assign windup = (drive_r <= floor_r && err_r[DW-1])
               || (drive_r >= ceil_r && !err_r[DW-1] && err_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_GOAL;
      mode_r      <= 1'b0;
      target_r    <= '0;
      gp_r        <= '0;
      gi_r        <= '0;
      lim_r       <= STEP_LIMIT_RST;
      floor_r     <= DRIVE_MIN;
      ceil_r      <= DRIVE_MAX;
      period_r    <= PERIOD_RST;
      drive_r     <= '0;
      acc_r       <= '0;
      last_r      <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ERROR_MODE:     mode_r   <= cfg_data[0];
          REG_DENSITY_TARGET: target_r <= cfg_data;
          REG_GAIN_PROP:      gp_r     <= cfg_data;
          REG_GAIN_INTEG:     gi_r     <= cfg_data;
          REG_STEP_LIMIT:     lim_r    <= cfg_data[LIM_W-1:0];
          REG_DRIVE_FLOOR:    floor_r  <= cfg_data;
          REG_DRIVE_CEILING:  ceil_r   <= cfg_data;
          REG_UPDATE_PERIOD:  period_r <= cfg_data[PER_W-1:0];
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            err_r   <= '0;
            did_r   <= 1'b0;
            if (!started_r) begin
              started_r <= 1'b1;
              last_r    <= in_ch.step_index;
              drive_r   <= clamp_drv({in_ch.start_value[DW-1], in_ch.start_value},
                                     floor_r, ceil_r);
              state_r   <= ST_FIN;
            end else begin
              drive_r <= clamp_drv({drive_r[DW-1], drive_r}, floor_r, ceil_r);
              if (due) begin
                last_r <= in_ch.step_index;
              end
              if (run) begin
                mag_r  <= mag_c;
                area_r <= in_ch.plane_area;
                dt_r   <= in_ch.step_length;
                op_r   <= OP_GOAL;
              end
              state_r <= run ? (mode_r ? ST_DIV : ST_ISSUE) : ST_FIN;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            err_r   <= sat32({{(SUM_W-DW-1){avg_diff[DW]}}, avg_diff});
            op_r    <= OP_INT;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          if (mac_done) begin
            state_r <= (op_r == OP_IGH) ? ST_DU : ST_ISSUE;
            unique case (op_r)
              OP_GOAL: begin
                err_r <= sat32(goal_diff);
                op_r  <= OP_INT;
              end
              OP_INT: begin
                if (!windup) acc_r <= sat48(int_sum);
                op_r <= OP_PRO;
              end
              OP_PRO: begin
                p_r  <= mac_res;
                op_r <= OP_IGL;
              end
              OP_IGL: begin
                op_r <= OP_IGH;
              end
              OP_IGH: begin
                i_r <= mac_res;
              end
              default: ;
            endcase
          end
        end
        ST_DU: begin
          du_r    <= du_lim[DW-1:0];
          state_r <= ST_DRV;
        end
        ST_DRV: begin
          drive_r <= clamp_drv(drive_diff, floor_r, ceil_r);
          did_r   <= 1'b1;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_drive_r <= drive_r;
            out_err_r   <= err_r;
            out_did_r   <= did_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_value = out_drive_r;
  assign out_ch.error_value = out_err_r;
  assign out_ch.did_update  = out_did_r;

  a_mac_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == ST_MUL)
    else $error("multiplier result outside multiply state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider result outside divide state");

  a_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("start flag dropped without reset");

  a_did_needs_area: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRV) |-> area_r != '0)
    else $error("drive update with zero area");

endmodule
`default_nettype wire

### hdl/pidaw_div.sv
`default_nettype none
module pidaw_div import pidaw_pkg::*; #(
  parameter int unsigned NUM_W = 47
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  dividend,
  input  logic [AREA_W-1:0] divisor,
  output logic              done,
  output logic [NUM_W-1:0]  quotient
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [CW-1:0]     cnt_r;
  logic              done_r;
  logic [AREA_W-1:0] rem_r;
  logic [AREA_W-1:0] dvs_r;
  logic [NUM_W-1:0]  quo_r;
  logic [AREA_W:0]   trial;
  logic              fits;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(NUM_W);
        rem_r <= '0;
        quo_r <= dividend;
        dvs_r <= divisor;
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == {{(CW-1){1'b0}}, 1'b1});
        quo_r  <= {quo_r[NUM_W-2:0], fits};
        if (fits) begin
          rem_r <= AREA_W'(trial - {1'b0, dvs_r});
        end else begin
          rem_r <= trial[AREA_W-1:0];
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

### hdl/pidaw_mac.sv
`default_nettype none
module pidaw_mac import pidaw_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic [MUL_W-1:0]         op_a,
  input  logic [MUL_W-1:0]         op_b,
  output logic                     done,
  output logic signed [WIDE_W-1:0] res
);

  logic                     v1_r, v2_r, done_r;
  logic                     clr_r, hi_r, neg1_r, neg2_r;
  logic [2*MUL_W-1:0]       mp_r;
  logic [PROD_W-1:0]        prod_r;
  logic signed [WIDE_W-1:0] res_r;
  logic [PROD_W-1:0]        mp_ext;
  logic [PROD_W-1:0]        shifted;
  logic [PROD_W-1:0]        lim;
  logic [PROD_W-1:0]        mag;

  assign mp_ext  = {{(PROD_W-2*MUL_W){1'b0}}, mp_r};
  assign shifted = prod_r >> FRAC_BITS;
  assign lim     = neg2_r ? WIDE_LIM_NEG : WIDE_LIM_POS;
  assign mag     = (shifted > lim) ? lim : shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= ctl.go;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      mp_r   <= op_a * op_b;
      clr_r  <= ctl.clr;
      hi_r   <= ctl.hi;
      neg1_r <= ctl.neg;
    end
    if (v1_r) begin
      prod_r <= (clr_r ? '0 : prod_r) + (hi_r ? (mp_ext << MUL_W) : mp_ext);
      neg2_r <= neg1_r;
    end
    if (v2_r) begin
      res_r <= neg2_r ? -$signed(mag[WIDE_W-1:0]) : $signed(mag[WIDE_W-1:0]);
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire
